### hw/rtl/flapdf_pkg.sv
// flapdf_pkg: shared types and constants for the frame deframer
// used by flap_frame_deframer_core; no dependencies
package flapdf_pkg;

  typedef enum logic [2:0] {
    PH_MARKER,
    PH_CHANNEL,
    PH_SEQ_HI,
    PH_SEQ_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } phase_t;

  localparam logic [1:0]  KIND_PAYLOAD    = 2'd0;
  localparam logic [1:0]  KIND_EMPTY      = 2'd1;
  localparam logic [1:0]  KIND_BAD_MARKER = 2'd2;

  localparam logic [7:0]  START_MARKER    = 8'h2a;
  localparam logic [7:0]  VERSION_CHANNEL = 8'h01;
  localparam logic [31:0] VERSION_VALUE   = 32'h0000_0001;
  localparam logic [15:0] VERSION_BYTES   = 16'd4;

endpackage

### hw/rtl/flap_frame_deframer_core.sv
// flap_frame_deframer_core: byte stream deframer, header parse and version check
// depends on flapdf_pkg

// Takes one received byte per cycle and gives at most one result word per byte,
// in the next cycle, from a result register. A byte is taken in every cycle unless
// a result is waiting and the output side stalls, so without stalls the rate is one
// byte per cycle. Frames carry a six-byte header (marker 0x2a, channel, 16-bit
// sequence, 16-bit length, big-endian) followed by the payload. A bad marker
// gives an error word and closes the block; on channel 1 the first four
// payload bytes must be version 1, else the block closes at the end of the
// frame. Once closed, bytes are taken and dropped until reset.
module flap_frame_deframer_core
  import flapdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_channel,
  output logic [15:0] out_sequence_res,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_byte_index,
  output logic        out_last_of_frame,
  output logic        out_version_ok,
  output logic        out_connected
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [31:0] vword_r, vword_nxt;
  logic        link_up_r, link_up_nxt;
  logic        closed_r, closed_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [15:0] index_r, index_nxt;
  logic        last_r, last_nxt;
  logic        vok_r, vok_nxt;
  logic [7:0]  ochan_r;
  logic [15:0] oseq_r, olen_r;
  logic        oconn_r;

  logic        in_acc;
  logic        produce;
  logic        fin;
  logic        vok;
  logic [16:0] idx_plus;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign idx_plus = {1'b0, offset_r} + 17'd1;

  always_comb begin
    phase_nxt   = phase_r;
    chan_nxt    = chan_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    offset_nxt  = offset_r;
    vword_nxt   = vword_r;
    link_up_nxt = link_up_r;
    closed_nxt  = closed_r;
    produce     = 1'b0;
    fin         = 1'b0;
    kind_nxt    = KIND_PAYLOAD;
    data_nxt    = '0;
    index_nxt   = '0;
    last_nxt    = 1'b0;
    if (!closed_r) begin
      case (phase_r)
        PH_MARKER: begin
          if (in_rx_byte != START_MARKER) begin
            chan_nxt   = '0;
            seq_nxt    = '0;
            len_nxt    = '0;
            closed_nxt = 1'b1;
            produce    = 1'b1;
            kind_nxt   = KIND_BAD_MARKER;
          end else begin
            phase_nxt = PH_CHANNEL;
          end
        end
        PH_CHANNEL: begin
          chan_nxt  = in_rx_byte;
          phase_nxt = PH_SEQ_HI;
        end
        PH_SEQ_HI: begin
          seq_nxt   = {in_rx_byte, 8'd0};
          phase_nxt = PH_SEQ_LO;
        end
        PH_SEQ_LO: begin
          seq_nxt   = {seq_r[15:8], in_rx_byte};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {in_rx_byte, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt    = {len_r[15:8], in_rx_byte};
          offset_nxt = '0;
          vword_nxt  = '0;
          if (len_nxt == 16'd0) begin
            fin      = 1'b1;
            produce  = 1'b1;
            kind_nxt = KIND_EMPTY;
            last_nxt = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          // first four payload bytes build the version word
          if (offset_r < VERSION_BYTES) begin
            vword_nxt = {vword_r[23:0], in_rx_byte};
          end
          offset_nxt = idx_plus[15:0];
          last_nxt   = idx_plus >= {1'b0, len_r};
          fin        = last_nxt;
          produce    = 1'b1;
          kind_nxt   = KIND_PAYLOAD;
          data_nxt   = in_rx_byte;
          index_nxt  = offset_r;
        end
        default: begin
          phase_nxt = PH_MARKER;
        end
      endcase
    end

    // end of frame: version check on the version channel
    vok = 1'b0;
    if (fin) begin
      phase_nxt = PH_MARKER;
      if (chan_nxt == VERSION_CHANNEL) begin
        vok = (len_nxt >= VERSION_BYTES) && (vword_nxt == VERSION_VALUE);
        if (vok) begin
          link_up_nxt = 1'b1;
        end else begin
          closed_nxt = 1'b1;
        end
      end
    end
    vok_nxt = vok;

    if (in_acc) begin
      out_valid_nxt = produce;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MARKER;
      chan_r      <= '0;
      seq_r       <= '0;
      len_r       <= '0;
      offset_r    <= '0;
      vword_r     <= '0;
      link_up_r   <= 1'b0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r   <= phase_nxt;
        chan_r    <= chan_nxt;
        seq_r     <= seq_nxt;
        len_r     <= len_nxt;
        offset_r  <= offset_nxt;
        vword_r   <= vword_nxt;
        link_up_r <= link_up_nxt;
        closed_r  <= closed_nxt;
      end
    end
  end

  // result payload register, loaded only with a new result
  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      kind_r  <= kind_nxt;
      data_r  <= data_nxt;
      index_r <= index_nxt;
      last_r  <= last_nxt;
      vok_r   <= vok_nxt;
      ochan_r <= chan_nxt;
      oseq_r  <= seq_nxt;
      olen_r  <= len_nxt;
      oconn_r <= link_up_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_data_byte     = data_r;
  assign out_channel       = ochan_r;
  assign out_sequence_res  = oseq_r;
  assign out_frame_length  = olen_r;
  assign out_byte_index    = index_r;
  assign out_last_of_frame = last_r;
  assign out_version_ok    = vok_r;
  assign out_connected     = oconn_r;

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r) else $error("closed flag dropped without reset");

  a_link_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    link_up_r |=> link_up_r) else $error("connected flag dropped without reset");

  a_closed_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && closed_r) |=> !out_valid_r) else $error("result from a closed block");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (offset_r < len_r))
    else $error("payload offset ran past frame length");

endmodule

### test/tb_top.sv
// tb_top: self-checking testbench for flap_frame_deframer_core, directed table then random frames
// depends on flapdf_pkg, flap_frame_deframer_core; words checked vs table or local predictor
module tb_top
  import flapdf_pkg::*;
();

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BYTES = 650;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  channel;
    logic [15:0] seq;
    logic [15:0] length;
    logic [15:0] index;
    logic        last;
    logic        version_ok;
    logic        connected;
  } frame_word_t;

  typedef struct packed {
    logic        typed;
    logic [7:0]  rx;
    frame_word_t word;
  } stim_row_t;

  typedef enum logic [1:0] {
    CLOSE_BAD_MARKER,
    CLOSE_VERSION_MISMATCH,
    CLOSE_SHORT_VERSION,
    CLOSE_EMPTY_VERSION
  } close_case_t;

  // empty frame, header extremes, then a channel 1 frame that brings the link up
  localparam stim_row_t DIRECTED [23] = '{
    '{1'b0, 8'h2a, '0}, '{1'b0, 8'h00, '0}, '{1'b0, 8'h00, '0},
    '{1'b0, 8'h00, '0}, '{1'b0, 8'h00, '0},
    '{1'b1, 8'h00, '{KIND_EMPTY, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000,
                     1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'h2a, '0}, '{1'b0, 8'hff, '0}, '{1'b0, 8'hff, '0},
    '{1'b0, 8'hff, '0}, '{1'b0, 8'h00, '0}, '{1'b0, 8'h01, '0},
    '{1'b1, 8'hff, '{KIND_PAYLOAD, 8'hff, 8'hff, 16'hffff, 16'h0001, 16'h0000,
                     1'b1, 1'b0, 1'b0}},
    '{1'b0, 8'h2a, '0}, '{1'b0, 8'h01, '0}, '{1'b0, 8'h80, '0},
    '{1'b0, 8'h01, '0}, '{1'b0, 8'h00, '0}, '{1'b0, 8'h04, '0},
    '{1'b0, 8'h00, '0}, '{1'b0, 8'h00, '0}, '{1'b0, 8'h00, '0},
    '{1'b1, 8'h01, '{KIND_PAYLOAD, 8'h01, 8'h01, 16'h8001, 16'h0004, 16'h0003,
                     1'b1, 1'b1, 1'b1}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_channel;
  logic [15:0] out_sequence_res;
  logic [15:0] out_frame_length;
  logic [15:0] out_byte_index;
  logic        out_last_of_frame;
  logic        out_version_ok;
  logic        out_connected;

  flap_frame_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_channel      (out_channel),
    .out_sequence_res (out_sequence_res),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_last_of_frame(out_last_of_frame),
    .out_version_ok   (out_version_ok),
    .out_connected    (out_connected)
  );

  // predictor state
  phase_t      fr_phase;
  logic [7:0]  fr_chan;
  logic [15:0] fr_seq;
  logic [15:0] fr_len;
  logic [15:0] fr_off;
  logic [31:0] fr_ver;
  logic        fr_link;
  logic        fr_closed;

  frame_word_t pending_words [$];
  int          burst_left;
  int          bytes_sent;
  int          frames_sent;
  int          err_count;
  int          idle_cycles;
  int          kind_seen [3];
  int          stall_ctr;
  int          stall_mode;
  close_case_t close_case;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // end of frame: version check on channel 1, back to hunting for a marker
  function automatic logic end_of_frame();
    logic vok;
    vok = 1'b0;
    if (fr_chan == VERSION_CHANNEL) begin
      vok = (fr_len >= VERSION_BYTES) && (fr_ver == VERSION_VALUE);
      if (vok) fr_link = 1'b1;
      else fr_closed = 1'b1;
    end
    fr_phase = PH_MARKER;
    return vok;
  endfunction

  task automatic deframe_step(input logic [7:0] b, output bit has_word,
                              output frame_word_t w);
    logic vok;
    logic last;
    logic [15:0] idx;
    has_word = 1'b0;
    w = '0;
    vok = 1'b0;
    if (!fr_closed) begin
      case (fr_phase)
        PH_MARKER: begin
          if (b != START_MARKER) begin
            fr_chan = '0;
            fr_seq = '0;
            fr_len = '0;
            fr_closed = 1'b1;
            has_word = 1'b1;
            w = '{KIND_BAD_MARKER, 8'h00, fr_chan, fr_seq, fr_len, 16'h0000,
                  1'b0, 1'b0, fr_link};
          end else begin
            fr_phase = PH_CHANNEL;
          end
        end
        PH_CHANNEL: begin
          fr_chan = b;
          fr_phase = PH_SEQ_HI;
        end
        PH_SEQ_HI: begin
          fr_seq = {b, 8'h00};
          fr_phase = PH_SEQ_LO;
        end
        PH_SEQ_LO: begin
          fr_seq[7:0] = b;
          fr_phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          fr_len = {b, 8'h00};
          fr_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          fr_len[7:0] = b;
          fr_off = '0;
          fr_ver = '0;
          if (fr_len == 16'd0) begin
            vok = end_of_frame();
            has_word = 1'b1;
            w = '{KIND_EMPTY, 8'h00, fr_chan, fr_seq, fr_len, 16'h0000,
                  1'b1, vok, fr_link};
          end else begin
            fr_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          idx = fr_off;
          last = ({16'd0, idx} + 32'd1) >= {16'd0, fr_len};
          if (idx < VERSION_BYTES) fr_ver = {fr_ver[23:0], b};
          fr_off = idx + 16'd1;
          if (last) vok = end_of_frame();
          has_word = 1'b1;
          w = '{KIND_PAYLOAD, b, fr_chan, fr_seq, fr_len, idx, last, vok, fr_link};
        end
        default: fr_phase = PH_MARKER;
      endcase
    end
  endtask

  // called at a falling edge, returns at the falling edge after the byte is taken
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input frame_word_t typed_word);
    int gap;
    bit has_word;
    frame_word_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_step(b, has_word, w);
    if (has_word) pending_words.push_back(typed ? typed_word : w);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] chan, input logic [15:0] seq,
                            input logic [15:0] len, input logic [31:0] ver);
    logic [7:0] b;
    send_byte(START_MARKER, 1'b0, '0);
    send_byte(chan, 1'b0, '0);
    send_byte(seq[15:8], 1'b0, '0);
    send_byte(seq[7:0], 1'b0, '0);
    send_byte(len[15:8], 1'b0, '0);
    send_byte(len[7:0], 1'b0, '0);
    for (int i = 0; i < int'(len); i++) begin
      if (i < 4) b = ver[31 - 8*i -: 8];
      else b = 8'($urandom);
      send_byte(b, 1'b0, '0);
    end
    frames_sent++;
  endtask

  // receiver stall pattern, mode picked at random from four
  always @(negedge clk) begin
    if (stall_ctr % 50 == 0) stall_mode = $urandom_range(0, 3);
    stall_ctr++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_ctr % 8) < 3);
    endcase
  end

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_data_byte, out_channel, out_sequence_res, out_frame_length,
              out_byte_index, out_last_of_frame, out_version_ok, out_connected};
      if (got.kind <= KIND_BAD_MARKER) kind_seen[got.kind]++;
      if (pending_words.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("unexpected word: kind %0d data %h ch %h seq %h len %h idx %h",
                   got.kind, got.data_byte, got.channel, got.seq, got.length, got.index);
        err_count++;
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          if (err_count < MAX_REPORTS) begin
            $display("mismatch exp: kind %0d data %h ch %h seq %h len %h idx %h last %b vok %b conn %b",
                     want.kind, want.data_byte, want.channel, want.seq, want.length,
                     want.index, want.last, want.version_ok, want.connected);
            $display("         got: kind %0d data %h ch %h seq %h len %h idx %h last %b vok %b conn %b",
                     got.kind, got.data_byte, got.channel, got.seq, got.length,
                     got.index, got.last, got.version_ok, got.connected);
          end
          err_count++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [7:0]  chan;
    logic [15:0] len;
    logic [31:0] ver;
    logic [7:0]  b;
    int          pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_stall = 1'b0;
    fr_phase = PH_MARKER;
    fr_chan = '0;
    fr_seq = '0;
    fr_len = '0;
    fr_off = '0;
    fr_ver = '0;
    fr_link = 1'b0;
    fr_closed = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    frames_sent = 0;
    err_count = 0;
    idle_cycles = 0;
    stall_ctr = 0;
    stall_mode = 0;
    kind_seen = '{0, 0, 0};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].word);
    frames_sent += 3;

    // well-formed frames only, anything broken would close the block for good
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = 16'd0;
      else if (pick < 75) len = 16'($urandom_range(1, 8));
      else if (pick < 93) len = 16'($urandom_range(9, 40));
      // long frames only while there is room left in the byte budget
      else if (bytes_sent + 320 < RANDOM_BYTES) len = 16'($urandom_range(250, 300));
      else len = 16'($urandom_range(9, 40));
      chan = 8'($urandom);
      ver = $urandom;
      if (chan == VERSION_CHANNEL || $urandom_range(0, 4) == 0) begin
        chan = VERSION_CHANNEL;
        ver = VERSION_VALUE;
        if (len < VERSION_BYTES) len = 16'($urandom_range(4, 12));
      end
      send_frame(chan, 16'($urandom), len, ver);
    end

    // one way of closing per run, then bytes that must be dropped
    close_case = close_case_t'($urandom_range(0, 3));
    case (close_case)
      CLOSE_BAD_MARKER: begin
        b = 8'($urandom);
        if (b == START_MARKER) b = ~b;
        send_byte(b, 1'b0, '0);
      end
      CLOSE_VERSION_MISMATCH: begin
        ver = $urandom;
        if (ver == VERSION_VALUE) ver = ver ^ 32'h80;
        send_frame(VERSION_CHANNEL, 16'($urandom), 16'($urandom_range(4, 8)), ver);
      end
      CLOSE_SHORT_VERSION:
        send_frame(VERSION_CHANNEL, 16'($urandom), 16'($urandom_range(1, 3)), $urandom);
      default: send_frame(VERSION_CHANNEL, 16'($urandom), 16'd0, $urandom);
    endcase
    for (int i = 0; i < 12; i++) begin
      b = (i == 3) ? START_MARKER : 8'($urandom);
      send_byte(b, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d bytes in %0d frames; words seen: %0d payload, %0d empty, %0d bad marker",
             bytes_sent, frames_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("run closed by %s, %0d mismatches", close_case.name(), err_count);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/flapdf_pkg.sv
hw/rtl/flap_frame_deframer_core.sv
test/tb_top.sv
